// ===== rtl/core/rycc_pkg.sv =====
package rycc_pkg;

  // Default number of fraction bits in a coefficient
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Integer bits above the fraction in a signed coefficient (|coef| < 4, plus sign)
  localparam int COEF_INT_BITS = 3;

  // Width of a signed channel value after its input offset is taken off
  localparam int CHAN_DIFF_W = 10;

  typedef struct packed {
    logic       op;
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
  } out_item_t;

  // Coefficients in millionths, indexed [mode][op][output][input].
  // Mode: studio swing, then full range. Op: RGB to YCbCr, then YCbCr to RGB.
  localparam int COEF_MIL [2][2][3][3] = '{
    '{
      '{ '{  257000,  504000,   98000 },
         '{ -148000, -291000,  439000 },
         '{  439000, -368000,  -71000 } },
      '{ '{ 1164000,       0, 1596000 },
         '{ 1164000, -392000, -813000 },
         '{ 1164000, 2017000,       0 } }
    },
    '{
      '{ '{  299000,  587000,  114000 },
         '{ -168736, -331264,  500000 },
         '{  500000, -418688,  -81312 } },
      '{ '{ 1000000,       0, 1402000 },
         '{ 1000000, -344136, -714136 },
         '{ 1000000, 1772000,       0 } }
    }
  };

  // Offset taken off each input channel, [mode][op][input]
  localparam logic [7:0] IN_OFF [2][2][3] = '{
    '{ '{ 8'd0, 8'd0,   8'd0   }, '{ 8'd16, 8'd128, 8'd128 } },
    '{ '{ 8'd0, 8'd0,   8'd0   }, '{ 8'd0,  8'd128, 8'd128 } }
  };

  // Offset added to each output channel, [mode][op][output]
  localparam logic [7:0] OUT_OFF [2][2][3] = '{
    '{ '{ 8'd16, 8'd128, 8'd128 }, '{ 8'd0, 8'd0, 8'd0 } },
    '{ '{ 8'd0,  8'd128, 8'd128 }, '{ 8'd0, 8'd0, 8'd0 } }
  };

  // Scale a value in millionths to a fixed-point coefficient, rounding the
  // magnitude half up and applying the sign afterwards
  function automatic longint coef_fx(input int mil, input int frac);
    longint mag;
    mag = (mil < 0) ? -longint'(mil) : longint'(mil);
    mag = ((mag <<< frac) + 64'sd500000) / 64'sd1000000;
    return (mil < 0) ? -mag : mag;
  endfunction

endpackage

// ===== rtl/core/rycc_coef.sv =====
module rycc_coef #(
  parameter int FRAC = rycc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                mode,
  input  logic                                op,
  output logic [2:0][2:0][FRAC+rycc_pkg::COEF_INT_BITS-1:0] coef_o,
  output logic [2:0][7:0]                     in_off_o,
  output logic [2:0][7:0]                     out_off_o
);
  import rycc_pkg::*;

  localparam int CW = FRAC + COEF_INT_BITS;

  logic [CW-1:0] tab [2][2][3][3];

  // Build the fixed-point coefficient table at elaboration
  for (genvar m = 0; m < 2; m++) begin : g_mode
    for (genvar o = 0; o < 2; o++) begin : g_op
      for (genvar i = 0; i < 3; i++) begin : g_out
        for (genvar j = 0; j < 3; j++) begin : g_in
          assign tab[m][o][i][j] = CW'(coef_fx(COEF_MIL[m][o][i][j], FRAC));
        end
      end
    end
  end

  // Select the coefficient set and offsets for this mode and direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef_o[i][j] = tab[mode][op][i][j];
      end
      in_off_o[i]  = IN_OFF[mode][op][i];
      out_off_o[i] = OUT_OFF[mode][op][i];
    end
  end

endmodule

// ===== rtl/core/rycc_dot.sv =====
module rycc_dot #(
  parameter int FRAC = rycc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic [2:0][7:0]                          chan,
  input  logic [2:0][7:0]                          in_off,
  input  logic [2:0][FRAC+rycc_pkg::COEF_INT_BITS-1:0] coef,
  input  logic [7:0]                               out_off,
  output logic [7:0]                               res
);
  import rycc_pkg::*;

  localparam int CW = FRAC + COEF_INT_BITS;
  localparam int PW = CW + CHAN_DIFF_W;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC - 1);

  logic signed [CHAN_DIFF_W-1:0] diff [3];
  logic signed [PW-1:0]          prod [3];
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          quo;
  logic signed [AW-1:0]          sum;

  // Remove input offsets and form the products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = $signed({2'b00, chan[j]}) - $signed({2'b00, in_off[j]});
      prod[j] = PW'($signed(coef[j])) * PW'(diff[j]);
    end
  end

  // Sum, round half up, add output offset
  always_comb begin
    acc = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]);
    quo = (acc + HALF) >>> FRAC;
    sum = quo + $signed({{(AW-8){1'b0}}, out_off});
  end

  // Clamp to the 8-bit range
  always_comb begin
    if (sum < 0) begin
      res = 8'd0;
    end else if (sum > AW'(255)) begin
      res = 8'd255;
    end else begin
      res = sum[7:0];
    end
  end

endmodule

// ===== rtl/core/rgb_ycbcr_color_convert_core.sv =====
// RGB <-> YCbCr pixel converter, BT.601 studio swing or JPEG full range.
//
// Input: a pixel transaction is taken at each rising edge with start high
// and busy low. in_data.op picks the direction (0 = RGB to YCbCr,
// 1 = YCbCr to RGB). busy is low whenever reset is released, so a pixel
// can be issued in every cycle.
// Output: out_valid pulses for one cycle with the converted pixel on
// out_data, once the pixel has passed the input register and then the
// result register. Throughput is one pixel per clock; the three
// multiply-accumulate channels between the two registers set that figure.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration: cfg_data carries the conversion mode (0 = studio swing,
// 1 = full range), written when cfg_valid and cfg_ready are high. Write it
// only while no pixel is in flight. The mode resets to studio swing.
// Reset: synchronous, active low; clears the mode and all valid flags so
// no result appears until a new pixel is taken.
module rgb_ycbcr_color_convert_core #(
  parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rycc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output rycc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import rycc_pkg::*;

  localparam int CW = COEF_FRAC_BITS + COEF_INT_BITS;

  logic             conv_mode_r;
  logic             in_vld_r;
  in_item_t         in_item_r;
  logic             item_mode_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;
  logic             accept;

  logic [2:0][2:0][CW-1:0] coef_w;
  logic [2:0][7:0]         in_off_w;
  logic [2:0][7:0]         out_off_w;
  logic [2:0][7:0]         chan_w;
  logic [2:0][7:0]         res_w;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      conv_mode_r <= cfg_data;
    end
  end

  // Capture the input transaction with the mode in force
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r   <= in_data;
      item_mode_r <= conv_mode_r;
    end
  end

  // Select coefficients and offsets
  rycc_coef #(
    .FRAC (COEF_FRAC_BITS)
  ) u_coef (
    .mode      (item_mode_r),
    .op        (in_item_r.op),
    .coef_o    (coef_w),
    .in_off_o  (in_off_w),
    .out_off_o (out_off_w)
  );

  assign chan_w = {in_item_r.chan_third, in_item_r.chan_second, in_item_r.chan_first};

  // One multiply-accumulate channel per output
  for (genvar i = 0; i < 3; i++) begin : g_dot
    rycc_dot #(
      .FRAC (COEF_FRAC_BITS)
    ) u_dot (
      .chan    (chan_w),
      .in_off  (in_off_w),
      .coef    (coef_w[i]),
      .out_off (out_off_w[i]),
      .res     (res_w[i])
    );
  end

  always_comb begin
    out_item_nxt.out_first  = res_w[0];
    out_item_nxt.out_second = res_w[1];
    out_item_nxt.out_third  = res_w[2];
  end

  // Advance to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // An accepted transaction reaches the input register
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_vld_r)
    else $error("accepted transaction did not reach the input register");

  // Every staged transaction yields exactly one result next cycle
  a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid_r)
    else $error("staged transaction produced no result");

  // No result without a staged transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_valid_r)
    else $error("result strobe without a staged transaction");

  // Reset clears the pipeline flags
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_vld_r && !out_valid_r && !conv_mode_r)
    else $error("reset did not clear pipeline state");

  // A mode write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> conv_mode_r == $past(cfg_data))
    else $error("mode write was lost");

endmodule

// ===== tb/rgb_ycbcr_color_convert_core_tb.sv =====
`timescale 1ns / 1ps

module rgb_ycbcr_color_convert_core_tb;
  import rycc_pkg::*;

  localparam int FRAC_BITS     = 14;
  localparam int PIPE_LATENCY  = 2;
  localparam int STALL_LIMIT   = 400;
  localparam int SEGMENT_ITEMS = 100;
  localparam int SEGMENTS      = 4;

  localparam logic MODE_STUDIO = 1'b0;
  localparam logic MODE_FULL   = 1'b1;
  localparam logic OP_TO_YCC   = 1'b0;
  localparam logic OP_TO_RGB   = 1'b1;

  // Conversion matrices in millionths, [mode][op][output][input]
  localparam int MATRIX_MIL [2][2][3][3] = '{
    '{
      '{ '{  257000,  504000,   98000 },
         '{ -148000, -291000,  439000 },
         '{  439000, -368000,  -71000 } },
      '{ '{ 1164000,       0, 1596000 },
         '{ 1164000, -392000, -813000 },
         '{ 1164000, 2017000,       0 } }
    },
    '{
      '{ '{  299000,  587000,  114000 },
         '{ -168736, -331264,  500000 },
         '{  500000, -418688,  -81312 } },
      '{ '{ 1000000,       0, 1402000 },
         '{ 1000000, -344136, -714136 },
         '{ 1000000, 1772000,       0 } }
    }
  };

  localparam int CHAN_IN_BIAS [2][2][3] = '{
    '{ '{ 0, 0, 0 }, '{ 16, 128, 128 } },
    '{ '{ 0, 0, 0 }, '{ 0,  128, 128 } }
  };

  localparam int CHAN_OUT_BIAS [2][2][3] = '{
    '{ '{ 16, 128, 128 }, '{ 0, 0, 0 } },
    '{ '{ 0,  128, 128 }, '{ 0, 0, 0 } }
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_data   = '0;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  out_item_t expected_pixels [$];
  logic      mode_shadow   = MODE_STUDIO;
  int        mismatch_count = 0;
  int        results_seen   = 0;
  int        mode_writes    = 0;
  int        idle_cycles    = 0;
  int        pixel_tally [2][2];
  bit        gaps_off       = 1'b0;

  rgb_ycbcr_color_convert_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fixed-point conversion of one pixel: round half up, then clamp to 8 bits
  function automatic out_item_t convert_pixel(input logic mode, input in_item_t px);
    longint    diff [3];
    longint    acc;
    longint    coef;
    longint    level;
    int        mil;
    logic [7:0] chan [3];
    logic [7:0] conv [3];
    out_item_t res;
    chan[0] = px.chan_first;
    chan[1] = px.chan_second;
    chan[2] = px.chan_third;
    for (int j = 0; j < 3; j++) begin
      diff[j] = longint'(chan[j]) - CHAN_IN_BIAS[mode][px.op][j];
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        mil  = MATRIX_MIL[mode][px.op][i][j];
        coef = (mil < 0) ? -longint'(mil) : longint'(mil);
        coef = ((coef <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
        if (mil < 0) coef = -coef;
        acc += coef * diff[j];
      end
      level = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      level += CHAN_OUT_BIAS[mode][px.op][i];
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      conv[i] = level[7:0];
    end
    res.out_first  = conv[0];
    res.out_second = conv[1];
    res.out_third  = conv[2];
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // Check results, record accepted pixels and mode writes, and guard against hangs
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $error("result with no pixel pending: %0d %0d %0d",
                 out_data.out_first, out_data.out_second, out_data.out_third);
          mismatch_count++;
        end else begin
          out_item_t exp_px;
          exp_px = expected_pixels.pop_front();
          compare_field("out_first", exp_px.out_first, out_data.out_first);
          compare_field("out_second", exp_px.out_second, out_data.out_second);
          compare_field("out_third", exp_px.out_third, out_data.out_third);
        end
      end
      if (start && !busy) begin
        expected_pixels.push_back(convert_pixel(mode_shadow, in_data));
        pixel_tally[mode_shadow][in_data.op]++;
      end
      if (cfg_valid && cfg_ready) begin
        mode_shadow = cfg_data;
        mode_writes++;
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
          $display("rgb_ycbcr_color_convert_core verification failed");
          $finish;
        end
      end
    end
  end

  // Drive one pixel, holding start across back-to-back transactions
  task automatic send_pixel(input in_item_t px);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and let every pending result come out
  task automatic settle_pipeline();
    start <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    settle_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_pixel(input logic op, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] c);
    in_item_t px;
    px.op          = op;
    px.chan_first  = a;
    px.chan_second = b;
    px.chan_third  = c;
    return px;
  endfunction

  // Mostly uniform, with a bias toward the ends to reach clamping
  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(0, 15));
      1:       return 8'($urandom_range(240, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Extremes, primaries and out-of-gamut corners in both directions
  task automatic test_corner_pixels();
    send_pixel(make_pixel(OP_TO_YCC, 8'd0,   8'd0,   8'd0));
    send_pixel(make_pixel(OP_TO_YCC, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(OP_TO_YCC, 8'd255, 8'd0,   8'd0));
    send_pixel(make_pixel(OP_TO_YCC, 8'd0,   8'd255, 8'd0));
    send_pixel(make_pixel(OP_TO_YCC, 8'd0,   8'd0,   8'd255));
    send_pixel(make_pixel(OP_TO_YCC, 8'hAA,  8'h55,  8'hAA));
    send_pixel(make_pixel(OP_TO_RGB, 8'd0,   8'd0,   8'd0));
    send_pixel(make_pixel(OP_TO_RGB, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(OP_TO_RGB, 8'd255, 8'd0,   8'd255));
    send_pixel(make_pixel(OP_TO_RGB, 8'd0,   8'd255, 8'd0));
    send_pixel(make_pixel(OP_TO_RGB, 8'd16,  8'd128, 8'd128));
    send_pixel(make_pixel(OP_TO_RGB, 8'h55,  8'hAA,  8'h55));
  endtask

  task automatic test_studio_after_reset();
    test_corner_pixels();
  endtask

  task automatic test_full_range_corners();
    write_mode(MODE_FULL);
    test_corner_pixels();
  endtask

  // Random pixels over several mode settings, with bursts and one full drain inside each segment
  task automatic test_random_stream();
    int pause_at;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       write_mode(MODE_STUDIO);
        1:       write_mode(MODE_FULL);
        default: write_mode(logic'($urandom_range(0, 1)));
      endcase
      pause_at = $urandom_range(10, SEGMENT_ITEMS - 10);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % 25 == 0) gaps_off = ($urandom_range(0, 2) == 0);
        if (n == pause_at) settle_pipeline();
        send_pixel(make_pixel(logic'($urandom_range(0, 1)), random_channel(),
                              random_channel(), random_channel()));
      end
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    for (int m = 0; m < 2; m++) begin
      for (int o = 0; o < 2; o++) pixel_tally[m][o] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_studio_after_reset();
    test_full_range_corners();
    test_random_stream();

    settle_pipeline();
    if (expected_pixels.size() != 0) begin
      $error("%0d expected results never arrived", expected_pixels.size());
      mismatch_count++;
    end
    $display("checked %0d results over %0d mode writes", results_seen, mode_writes);
    $display("studio: %0d to YCbCr, %0d to RGB; full range: %0d to YCbCr, %0d to RGB",
             pixel_tally[MODE_STUDIO][OP_TO_YCC], pixel_tally[MODE_STUDIO][OP_TO_RGB],
             pixel_tally[MODE_FULL][OP_TO_YCC], pixel_tally[MODE_FULL][OP_TO_RGB]);
    if (mismatch_count == 0) begin
      $display("rgb_ycbcr_color_convert_core verification clean");
    end else begin
      $display("rgb_ycbcr_color_convert_core verification failed");
    end
    $finish;
  end

endmodule
